>>> src/erfc_erf_approximation_assert.svh
// assertion macros for the erfc/erf pipeline
// used by the top level; expects clk and rst_n in scope
`ifndef ERFC_ERF_APPROXIMATION_ASSERT_SVH
`define ERFC_ERF_APPROXIMATION_ASSERT_SVH

// same-cycle implication
`define ERFCEA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erfcea same-cycle check failed");

// next-cycle implication
`define ERFCEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erfcea next-cycle check failed");

`endif

>>> src/erfcea_pkg.sv
// shared constants, stage counts and coefficient tables of the erfc/erf pipeline
// no dependencies
`default_nettype none

package erfcea_pkg;

  localparam int WQ           = 30;
  localparam int ARG_FRAC_DEF = 13;
  localparam int RES_FRAC_DEF = 15;
  localparam int X_W          = 16;
  localparam int RES_W        = 16;
  localparam int T_W          = 31;
  localparam int H_W          = 34;
  localparam int E_W          = 31;

  localparam int REC_ST      = T_W + 1;
  localparam int POLY_ST     = 5;
  localparam int EXP_CORE_ST = 22;
  localparam int EXP_DLY     = REC_ST + POLY_ST - EXP_CORE_ST;
  localparam int FIN_ST      = 2;
  localparam int NUM_ST      = REC_ST + POLY_ST + FIN_ST;

  function automatic longint unsigned to_q30(input longint unsigned m);
    return ((m << WQ) + 64'd500000000) / 64'd1000000000;
  endfunction

  localparam longint unsigned P_Q30 = to_q30(64'd327591100);

  function automatic logic signed [H_W-1:0] coef_q30(input int idx);
    logic [H_W-1:0] m;
    logic           neg;
    case (idx)
      0: begin m = H_W'(to_q30(64'd254829592));  neg = 1'b0; end
      1: begin m = H_W'(to_q30(64'd284496736));  neg = 1'b1; end
      2: begin m = H_W'(to_q30(64'd1421413741)); neg = 1'b0; end
      3: begin m = H_W'(to_q30(64'd1453152027)); neg = 1'b1; end
      4: begin m = H_W'(to_q30(64'd1061405429)); neg = 1'b0; end
      default: begin m = '0; neg = 1'b0; end
    endcase
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

`default_nettype wire

>>> src/erfcea_if.sv
// valid/ready channel interfaces for argument and result transactions
// depends on erfcea_pkg
`default_nettype none

interface erfcea_in_if import erfcea_pkg::*;;
  logic           valid;
  logic           ready;
  logic [X_W-1:0] x_value;
  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface erfcea_out_if import erfcea_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] erfc_value;
  logic [RES_W-1:0] erf_value;
  modport source (output valid, output erfc_value, output erf_value, input ready);
  modport sink   (input valid, input erfc_value, input erf_value, output ready);
endinterface

`default_nettype wire

>>> src/erfcea_recip.sv
// t = 1/(1 + p*x): p*x multiply stage, then a one-bit-per-stage restoring divider
// depends on erfcea_pkg
`default_nettype none

module erfcea_recip import erfcea_pkg::*; #(
  parameter int ARG_FRACTION_BITS = ARG_FRAC_DEF
) (
  input  wire logic              clk,
  input  wire logic [REC_ST-1:0] ld,
  input  wire logic [X_W-1:0]    x,
  output logic      [T_W-1:0]    t
);

  localparam int PQ_W = 29;
  localparam int PW   = PQ_W + X_W + 1;
  localparam int PXW  = PW - ARG_FRACTION_BITS;
  localparam int DW   = ((PXW > WQ) ? PXW : WQ) + 1;
  localparam int NB   = T_W;
  localparam int NW   = 2 * WQ + 1;
  localparam logic [PQ_W-1:0] PQ = PQ_W'(P_Q30);

  logic [PXW-1:0] px_r, px_nxt;
  logic [PW-1:0]  px_full;

  always_comb begin
    px_full = PW'(PQ) * PW'(x) + (PW'(1) << (ARG_FRACTION_BITS - 1));
    px_nxt  = PXW'(px_full >> ARG_FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) px_r <= px_nxt;
  end

  logic [DW-1:0] d0;
  logic [NW-1:0] n0;

  always_comb begin
    d0 = (DW'(1) << WQ) + DW'(px_r);
    n0 = (NW'(1) << (2 * WQ)) + NW'(d0 >> 1);
  end

  logic [DW-1:0] rem_r [NB];
  logic [DW-1:0] d_r   [NB];
  logic [NB-1:0] n_r   [NB];
  logic [NB-1:0] q_r   [NB];

  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [DW-1:0] rem_in, d_in, rem_nxt;
    logic [NB-1:0] n_in, q_in, q_nxt;
    logic [DW:0]   shifted;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(n0[NW-1:NB]);
      assign d_in   = d0;
      assign n_in   = n0[NB-1:0];
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign n_in   = n_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      shifted = {rem_in, n_in[NB-1-k]};
      ge      = shifted >= {1'b0, d_in};
      rem_nxt = ge ? DW'(shifted - {1'b0, d_in}) : DW'(shifted);
      q_nxt   = q_in | (NB'(ge) << (NB - 1 - k));
    end

    always_ff @(posedge clk) begin
      if (ld[k+1]) begin
        rem_r[k] <= rem_nxt;
        d_r[k]   <= d_in;
        n_r[k]   <= n_in;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign t = q_r[NB-1];

endmodule

`default_nettype wire

>>> src/erfcea_poly.sv
// horner evaluation of the five-term polynomial in t, one product per stage
// depends on erfcea_pkg
`default_nettype none

module erfcea_poly import erfcea_pkg::*; (
  input  wire logic                  clk,
  input  wire logic [POLY_ST-1:0]    ld,
  input  wire logic [T_W-1:0]        t,
  output logic signed [H_W-1:0]      h
);

  localparam int FW = H_W + T_W;

  // signed by unsigned q30 product, rounded with ties away from zero
  function automatic logic signed [H_W-1:0] smul(input logic signed [H_W-1:0] a,
                                                 input logic [T_W-1:0] b);
    logic [H_W-1:0] mag;
    logic [FW-1:0]  full;
    logic [H_W-1:0] pr;
    mag  = a[H_W-1] ? H_W'(-a) : H_W'(a);
    full = FW'(mag) * FW'(b) + (FW'(1) << (WQ - 1));
    pr   = H_W'(full >> WQ);
    return a[H_W-1] ? -$signed(pr) : $signed(pr);
  endfunction

  logic signed [H_W-1:0] h_r [POLY_ST];
  logic        [T_W-1:0] t_r [POLY_ST];

  for (genvar j = 0; j < POLY_ST; j++) begin : g_stage
    logic signed [H_W-1:0] h_in, h_nxt, prod;
    logic        [T_W-1:0] t_in;

    if (j == 0) begin : g_first
      assign h_in = coef_q30(4);
      assign t_in = t;
    end else begin : g_rest
      assign h_in = h_r[j-1];
      assign t_in = t_r[j-1];
    end

    if (j < POLY_ST - 1) begin : g_horner
      localparam logic signed [H_W-1:0] C = coef_q30(POLY_ST - 2 - j);
      always_comb begin
        prod  = smul(h_in, t_in);
        h_nxt = C + prod;
      end
    end else begin : g_last
      // a negative polynomial is taken as zero
      always_comb begin
        prod  = smul(h_in, t_in);
        h_nxt = prod[H_W-1] ? '0 : prod;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        h_r[j] <= h_nxt;
        t_r[j] <= t_in;
      end
    end
  end

  assign h = h_r[POLY_ST-1];

endmodule

`default_nettype wire

>>> src/erfcea_exp.sv
// exp(-x*x): alignment delay, square, short taylor series, then ten squarings
// depends on erfcea_pkg
`default_nettype none

module erfcea_exp import erfcea_pkg::*; #(
  parameter int ARG_FRACTION_BITS = ARG_FRAC_DEF
) (
  input  wire logic                          clk,
  input  wire logic [EXP_DLY+EXP_CORE_ST-1:0] ld,
  input  wire logic [X_W-1:0]                x,
  output logic      [E_W-1:0]                e
);

  localparam int SQ_W  = 2 * X_W;
  localparam bit Y_UP  = (2 * ARG_FRACTION_BITS <= WQ);
  localparam int YW    = Y_UP ? SQ_W + WQ - 2 * ARG_FRACTION_BITS
                              : SQ_W - (2 * ARG_FRACTION_BITS - WQ) + 1;
  localparam int HALV  = 10;
  localparam int UW    = YW - HALV + 1;
  localparam int MW    = UW + E_W;
  localparam int PMW   = UW + 1;
  localparam int NUMW  = UW + 2;
  localparam int RSH   = 36;
  localparam int DPW   = NUMW + RSH + 1;
  localparam int TAY   = 5;
  localparam int SQS   = 10;
  localparam int E0    = EXP_DLY;
  localparam logic [E_W-1:0] WONE = E_W'(1) << WQ;

  // delay so that e meets the polynomial result
  logic [X_W-1:0] dl_r [EXP_DLY];
  for (genvar i = 0; i < EXP_DLY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (ld[i]) dl_r[i] <= (i == 0) ? x : dl_r[(i == 0) ? 0 : i - 1];
    end
  end

  logic [SQ_W-1:0] sq_r;
  always_ff @(posedge clk) begin
    if (ld[E0]) sq_r <= SQ_W'(dl_r[EXP_DLY-1]) * SQ_W'(dl_r[EXP_DLY-1]);
  end

  logic [YW-1:0] y;
  if (Y_UP) begin : g_yup
    assign y = YW'(sq_r) << (WQ - 2 * ARG_FRACTION_BITS);
  end else begin : g_ydn
    logic [SQ_W:0] ysum;
    assign ysum = {1'b0, sq_r} + ((SQ_W + 1)'(1) << (2 * ARG_FRACTION_BITS - WQ - 1));
    assign y    = YW'(ysum >> (2 * ARG_FRACTION_BITS - WQ));
  end

  logic [UW-1:0] u_r;
  logic [YW:0]   ur_sum;
  assign ur_sum = {1'b0, y} + ((YW + 1)'(1) << (HALV - 1));
  always_ff @(posedge clk) begin
    if (ld[E0+1]) u_r <= UW'(ur_sum >> HALV);
  end

  // taylor stages: a product stage then a divide-by-k stage
  logic [UW-1:0]  um_r [TAY];
  logic [PMW-1:0] pm_r [TAY];
  logic [UW-1:0]  ud_r [TAY];
  logic [E_W-1:0] sd_r [TAY];

  for (genvar i = 0; i < TAY; i++) begin : g_tay
    localparam int K = TAY - i;
    localparam longint unsigned RC = ((64'd1 << RSH) + K - 1) / K;
    logic [UW-1:0]  u_in;
    logic [E_W-1:0] s_in, s_nxt;
    logic [MW-1:0]  mfull;
    logic [NUMW-1:0] num;
    logic [DPW-1:0] dprod;
    logic [DPW-1:0] qv;

    if (i == 0) begin : g_first
      assign u_in = u_r;
      assign s_in = WONE;
    end else begin : g_rest
      assign u_in = ud_r[i-1];
      assign s_in = sd_r[i-1];
    end

    assign mfull = MW'(u_in) * MW'(s_in) + (MW'(1) << (WQ - 1));

    always_comb begin
      num   = NUMW'(pm_r[i]) + NUMW'(K / 2);
      dprod = DPW'(num) * DPW'(RC);
      qv    = dprod >> RSH;
      s_nxt = (qv >= DPW'(WONE)) ? '0 : WONE - E_W'(qv);
    end

    always_ff @(posedge clk) begin
      if (ld[E0+2+2*i]) begin
        pm_r[i] <= PMW'(mfull >> WQ);
        um_r[i] <= u_in;
      end
      if (ld[E0+3+2*i]) begin
        sd_r[i] <= s_nxt;
        ud_r[i] <= um_r[i];
      end
    end
  end

  localparam int SW = 2 * E_W;
  logic [E_W-1:0] ss_r [SQS];

  for (genvar j = 0; j < SQS; j++) begin : g_sq
    logic [E_W-1:0] s_in;
    logic [SW-1:0]  full;
    if (j == 0) begin : g_first
      assign s_in = sd_r[TAY-1];
    end else begin : g_rest
      assign s_in = ss_r[j-1];
    end
    assign full = SW'(s_in) * SW'(s_in) + (SW'(1) << (WQ - 1));
    always_ff @(posedge clk) begin
      if (ld[E0+2+2*TAY+j]) ss_r[j] <= E_W'(full >> WQ);
    end
  end

  assign e = ss_r[SQS-1];

endmodule

`default_nettype wire

>>> src/erfc_erf_approximation.sv
// erfc(x) and erf(x) by the five-term rational approximation, fully pipelined
// depends on erfcea_pkg, erfcea_if, erfcea_recip, erfcea_poly, erfcea_exp
//
// usage:
//   in_chan (sink) takes one unsigned fixed-point argument x_value per
//   transaction; out_chan (source) returns erfc_value and erf_value, both
//   with RESULT_FRACTION_BITS fraction bits and saturated to 0..1.
//   from an accepted argument to its result transaction the pipeline runs
//   through 32 stages for p*x and the one-bit-per-stage reciprocal,
//   5 horner stages, 2 final product and rounding stages; exp(-x*x) runs
//   alongside on its own delay line.
//   throughput is one transaction per cycle while in_chan.ready is high; each stage holds a valid bit.
//   when the receiver stalls, results stay in their stages and empty stages
//   still fill, so in_chan.ready drops only once every stage is occupied.
//   synchronous reset clears all valid bits; the data registers are not reset.
`default_nettype none
`include "erfc_erf_approximation_assert.svh"

module erfc_erf_approximation import erfcea_pkg::*; #(
  parameter int ARG_FRACTION_BITS    = ARG_FRAC_DEF,
  parameter int RESULT_FRACTION_BITS = RES_FRAC_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  erfcea_in_if.sink     in_chan,
  erfcea_out_if.source  out_chan
);

  localparam int W_W  = H_W + 1;
  localparam int FPW  = (H_W - 1) + E_W;
  localparam int SH   = WQ - RESULT_FRACTION_BITS;
  localparam logic [W_W:0] ONE_R = (W_W + 1)'(1) << RESULT_FRACTION_BITS;

  logic [NUM_ST-1:0] v_r;
  logic [NUM_ST:0]   ld;

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    ld[NUM_ST] = out_chan.ready;
    for (int s = NUM_ST - 1; s >= 0; s--) begin
      ld[s] = !v_r[s] || ld[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NUM_ST; s++) begin
        if (ld[s]) v_r[s] <= (s == 0) ? in_chan.valid : v_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  logic [T_W-1:0]        t;
  logic signed [H_W-1:0] h;
  logic [E_W-1:0]        e;

  erfcea_recip #(.ARG_FRACTION_BITS(ARG_FRACTION_BITS)) u_recip (
    .clk (clk),
    .ld  (ld[REC_ST-1:0]),
    .x   (in_chan.x_value),
    .t   (t)
  );

  erfcea_poly u_poly (
    .clk (clk),
    .ld  (ld[REC_ST+POLY_ST-1:REC_ST]),
    .t   (t),
    .h   (h)
  );

  erfcea_exp #(.ARG_FRACTION_BITS(ARG_FRACTION_BITS)) u_exp (
    .clk (clk),
    .ld  (ld[REC_ST+POLY_ST-1:0]),
    .x   (in_chan.x_value),
    .e   (e)
  );

  // final product erfc = poly * exp(-x*x) in q30
  logic [W_W-1:0] w_r;
  logic [FPW-1:0] wfull;
  assign wfull = FPW'(h[H_W-2:0]) * FPW'(e) + (FPW'(1) << (WQ - 1));

  always_ff @(posedge clk) begin
    if (ld[REC_ST+POLY_ST]) w_r <= W_W'(wfull >> WQ);
  end

  logic [W_W:0] rnd, sat;
  if (SH > 0) begin : g_round
    assign rnd = ({1'b0, w_r} + ((W_W + 1)'(1) << ((SH > 0) ? SH - 1 : 0))) >> SH;
  end else begin : g_noround
    assign rnd = {1'b0, w_r};
  end
  assign sat = (rnd > ONE_R) ? ONE_R : rnd;

  logic [RES_W-1:0] erfc_r, erf_r;
  always_ff @(posedge clk) begin
    if (ld[REC_ST+POLY_ST+1]) begin
      erfc_r <= RES_W'(sat);
      erf_r  <= RES_W'(ONE_R - sat);
    end
  end

  assign in_chan.ready       = ld[0];
  assign out_chan.valid      = v_r[NUM_ST-1];
  assign out_chan.erfc_value = erfc_r;
  assign out_chan.erf_value  = erf_r;

  logic acc_in, acc_out;
  assign acc_in  = in_chan.valid && in_chan.ready;
  assign acc_out = out_chan.valid && out_chan.ready;

  `ERFCEA_ASSERT_NOW(a_sum_one, out_chan.valid, RES_W'(out_chan.erfc_value + out_chan.erf_value) == RES_W'(ONE_R))
  `ERFCEA_ASSERT_NEXT(a_fill, acc_in && !acc_out, $countones(v_r) == $past($countones(v_r)) + 1)
  `ERFCEA_ASSERT_NEXT(a_drain, !acc_in && acc_out, $countones(v_r) + 1 == $past($countones(v_r)))

endmodule

`default_nettype wire
